// ===== rtl/isd_pkg.sv =====
// Shared types and constants of the interleaved sample deframer.
// No dependencies; every other file of the block but isd_if imports this package.
`default_nettype none

package isd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHANNEL_COUNT    = 3'd0;
  localparam logic [2:0] CFG_BYTES_PER_SAMPLE = 3'd1;
  localparam logic [2:0] CFG_HEADER_LENGTH    = 3'd2;
  localparam logic [2:0] CFG_TRAILER_LENGTH   = 3'd3;
  localparam logic [2:0] CFG_LSB_FIRST        = 3'd4;

  // Layout limits
  localparam int MAX_EMIT_CHANNELS = 16;
  localparam int MAX_TIME_BYTES    = 4;
  localparam int MAX_CHANNELS      = 64;
  localparam int MAX_SAMPLE_BYTES  = 4;

  // Result kinds
  localparam logic RK_SAMPLE  = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Frame status codes
  localparam logic FS_OK        = 1'b0;
  localparam logic FS_MALFORMED = 1'b1;

  // Front sequencer states
  typedef enum logic [1:0] {
    FR_RUN,
    FR_DIV,
    FR_FIN
  } isd_fstate_t;

  // Work handed from front to back: up to one sample and one summary per byte
  typedef struct packed {
    logic        has_smp;
    logic [3:0]  chan;
    logic [31:0] value;
    logic        send;
    logic        has_sum;
    logic        status;
    logic [15:0] total;
    logic [31:0] dtime;
  } isd_op_t;

endpackage

`default_nettype wire

// ===== rtl/isd_if.sv =====
// Valid/ready channel interfaces of the deframer: frame bytes in, results out.
// Depends on nothing.
`default_nettype none

interface isd_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [15:0] frame_length;

  modport source (output valid, data_byte, frame_start, frame_length, input ready);
  modport sink   (input valid, data_byte, frame_start, frame_length, output ready);
endinterface

interface isd_result_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [3:0]         channel_index;
  logic signed [31:0] sample_value;
  logic               sample_end;
  logic               frame_status;
  logic [15:0]        sample_total;
  logic [31:0]        device_time;
  logic               last_result;

  modport source (output valid, result_kind, channel_index, sample_value, sample_end,
                  frame_status, sample_total, device_time, last_result, input ready);
  modport sink   (input valid, result_kind, channel_index, sample_value, sample_end,
                  frame_status, sample_total, device_time, last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/isd_mod.sv =====
// Bit-serial remainder unit: one restoring step per cycle, 16 steps.
// Used by the front to check that the frame data is a whole number of strides.
`default_nettype none

module isd_mod
  import isd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [8:0]  divisor,
  output logic             done,
  output logic             nonzero
);

  localparam int DW = 16;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [8:0]    rem;
  logic [CW-1:0] cnt;
  logic [9:0]    trial;
  logic [9:0]    trial_sub;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem, quo[DW-1]};
    trial_sub = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial_sub[8:0];
      end else begin
        rem <= trial[8:0];
      end
    end
  end

  assign nonzero = (rem != '0);

endmodule

`default_nettype wire

// ===== rtl/isd_front.sv =====
// Front of the deframer: configuration registers, frame check, byte classification
// and sample assembly. Uses isd_pkg, isd_if and the isd_mod remainder unit.
`default_nettype none

module isd_front
  import isd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  isd_byte_if.sink    byte_ch,
  input  wire logic   q_full,
  output logic        push,
  output isd_op_t     push_op
);

  localparam logic [6:0] EMIT_LIM = 7'(MAX_EMIT_CHANNELS);
  localparam logic [7:0] TIME_LIM = 8'(MAX_TIME_BYTES);
  localparam logic [6:0] CH_LIM   = 7'(MAX_CHANNELS);
  localparam logic [2:0] BPS_LIM  = 3'(MAX_SAMPLE_BYTES);

  // Configuration
  logic [6:0] channel_count;
  logic [2:0] bytes_per_sample;
  logic [7:0] header_length;
  logic [7:0] trailer_length;
  logic       lsb_first;

  // Frame state
  logic [15:0] byte_position;
  logic [15:0] bytes_remaining;
  logic        frame_valid;
  logic [1:0]  byte_in_sample;
  logic [5:0]  channel_counter;
  logic [31:0] sample_accumulator;
  logic [15:0] sample_counter;
  logic [31:0] time_accumulator;

  // Held start byte
  logic [7:0]  lat_byte;
  logic [15:0] lat_len;
  logic        lat_fast_bad;
  logic        mod_bad;

  isd_fstate_t state, state_next;

  logic        accept;
  logic        mod_start;
  logic        mod_done;
  logic        mod_nonzero;
  logic [9:0]  stride;
  logic [8:0]  overhead;
  logic        fast_bad;
  logic [15:0] payload_len;

  // Step inputs
  logic        p_en;
  logic [7:0]  p_byte;
  logic        p_start;
  logic [15:0] p_len;
  logic        p_bad;

  // Effective and next state
  logic        e_fv, n_fv;
  logic [15:0] e_br, n_br;
  logic [15:0] e_bp, n_bp;
  logic [1:0]  e_bis, n_bis;
  logic [5:0]  e_cc, n_cc;
  logic [31:0] e_acc, n_acc;
  logic [15:0] e_scnt, n_scnt;
  logic [31:0] e_tacc, n_tacc;
  logic [7:0]  tidx;
  logic [7:0]  tb;
  logic [31:0] acc_new;
  logic [6:0]  c_inc;
  logic [6:0]  nch;
  logic        smp_fin;
  isd_op_t     op;

  function automatic logic [31:0] sext(input logic [31:0] v, input logic [1:0] last_idx);
    logic [31:0] r;
    case (last_idx)
      2'd0:    r = {{24{v[7]}}, v[7:0]};
      2'd1:    r = {{16{v[15]}}, v[15:0]};
      2'd2:    r = {{8{v[23]}}, v[23:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= 7'd1;
      bytes_per_sample <= 3'd2;
      header_length    <= 8'd0;
      trailer_length   <= 8'd0;
      lsb_first        <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT:    channel_count    <= cfg_data[6:0];
        CFG_BYTES_PER_SAMPLE: bytes_per_sample <= cfg_data[2:0];
        CFG_HEADER_LENGTH:    header_length    <= cfg_data;
        CFG_TRAILER_LENGTH:   trailer_length   <= cfg_data;
        CFG_LSB_FIRST:        lsb_first        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Length checks that need no division
  always_comb begin
    stride   = 10'(channel_count * bytes_per_sample);
    overhead = {1'b0, header_length} + {1'b0, trailer_length};
    fast_bad = (channel_count > CH_LIM) || (bytes_per_sample > BPS_LIM) ||
               (stride == '0) || ({1'b0, byte_ch.frame_length} < {8'b0, overhead});
    payload_len = byte_ch.frame_length - {7'b0, overhead};
  end

  isd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (payload_len),
    .divisor  (stride[8:0]),
    .done     (mod_done),
    .nonzero  (mod_nonzero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the start byte through the check; pass other bytes straight on
  always_comb begin
    state_next    = state;
    byte_ch.ready = 1'b0;
    mod_start     = 1'b0;
    p_en          = 1'b0;
    p_byte        = byte_ch.data_byte;
    p_start       = 1'b0;
    p_len         = byte_ch.frame_length;
    p_bad         = 1'b0;
    case (state)
      FR_RUN: begin
        byte_ch.ready = !q_full;
        if (accept) begin
          if (byte_ch.frame_start) begin
            if (fast_bad) begin
              state_next = FR_FIN;
            end else begin
              mod_start  = 1'b1;
              state_next = FR_DIV;
            end
          end else begin
            p_en = 1'b1;
          end
        end
      end
      FR_DIV: begin
        if (mod_done) begin
          state_next = FR_FIN;
        end
      end
      FR_FIN: begin
        p_byte  = lat_byte;
        p_start = 1'b1;
        p_len   = lat_len;
        p_bad   = lat_fast_bad | mod_bad;
        if (!q_full) begin
          p_en       = 1'b1;
          state_next = FR_RUN;
        end
      end
      default: state_next = FR_RUN;
    endcase
  end

  assign accept = byte_ch.valid && byte_ch.ready;

  // Hold the start byte while its length is checked
  always_ff @(posedge clk) begin
    if (accept && byte_ch.frame_start) begin
      lat_byte     <= byte_ch.data_byte;
      lat_len      <= byte_ch.frame_length;
      lat_fast_bad <= fast_bad;
      mod_bad      <= 1'b0;
    end else if (mod_done) begin
      mod_bad <= mod_nonzero;
    end
  end

  // One deframing step on the selected byte
  always_comb begin
    if (p_start) begin
      e_fv   = !p_bad && (p_len != '0);
      e_br   = e_fv ? p_len : '0;
      e_bp   = '0;
      e_bis  = '0;
      e_cc   = '0;
      e_acc  = '0;
      e_scnt = '0;
      e_tacc = '0;
    end else begin
      e_fv   = frame_valid;
      e_br   = bytes_remaining;
      e_bp   = byte_position;
      e_bis  = byte_in_sample;
      e_cc   = channel_counter;
      e_acc  = sample_accumulator;
      e_scnt = sample_counter;
      e_tacc = time_accumulator;
    end
    n_fv    = e_fv;
    n_br    = e_br;
    n_bp    = e_bp;
    n_bis   = e_bis;
    n_cc    = e_cc;
    n_acc   = e_acc;
    n_scnt  = e_scnt;
    n_tacc  = e_tacc;
    op      = '0;
    tidx    = trailer_length - e_br[7:0];
    tb      = (trailer_length < TIME_LIM) ? trailer_length : TIME_LIM;
    acc_new = lsb_first ? (e_acc | ({24'b0, p_byte} << {e_bis, 3'b000}))
                        : {e_acc[23:0], p_byte};
    c_inc   = {1'b0, e_cc} + 7'd1;
    nch     = (channel_count < EMIT_LIM) ? channel_count : EMIT_LIM;
    smp_fin = (({1'b0, e_bis} + 3'd1) >= bytes_per_sample) || (e_bis == 2'd3);

    if (p_start && (p_bad || (p_len == '0))) begin
      op.has_sum = 1'b1;
      op.status  = p_bad ? FS_MALFORMED : FS_OK;
    end

    if (e_fv && (e_br != '0)) begin
      if ({8'b0, trailer_length} >= e_br) begin
        // Trailer: gather the timestamp bytes
        if (tidx < tb) begin
          if (lsb_first) begin
            if (tidx < 8'd4) begin
              n_tacc = e_tacc | ({24'b0, p_byte} << {tidx[1:0], 3'b000});
            end
          end else begin
            n_tacc = {e_tacc[23:0], p_byte};
          end
        end
      end else if (e_bp >= {8'b0, header_length}) begin
        // Sample data: assemble, then emit and advance the channel
        if (smp_fin) begin
          if ({1'b0, e_cc} < EMIT_LIM) begin
            op.has_smp = 1'b1;
            op.chan    = e_cc[3:0];
            op.value   = sext(acc_new, e_bis);
            op.send    = (c_inc >= nch);
          end
          n_acc = '0;
          n_bis = '0;
          if (c_inc >= channel_count) begin
            n_cc   = '0;
            n_scnt = e_scnt + 16'd1;
          end else begin
            n_cc = c_inc[5:0];
          end
        end else begin
          n_acc = acc_new;
          n_bis = e_bis + 2'd1;
        end
      end
      n_bp = e_bp + 16'd1;
      n_br = e_br - 16'd1;
      if (n_br == '0) begin
        op.has_sum = 1'b1;
        op.status  = FS_OK;
        op.total   = n_scnt;
        op.dtime   = n_tacc;
        n_fv       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid        <= 1'b0;
      bytes_remaining    <= '0;
      byte_position      <= '0;
      byte_in_sample     <= '0;
      channel_counter    <= '0;
      sample_accumulator <= '0;
      sample_counter     <= '0;
      time_accumulator   <= '0;
    end else if (p_en) begin
      frame_valid        <= n_fv;
      bytes_remaining    <= n_br;
      byte_position      <= n_bp;
      byte_in_sample     <= n_bis;
      channel_counter    <= n_cc;
      sample_accumulator <= n_acc;
      sample_counter     <= n_scnt;
      time_accumulator   <= n_tacc;
    end
  end

  assign push    = p_en && (op.has_smp || op.has_sum);
  assign push_op = op;

endmodule

`default_nettype wire

// ===== rtl/isd_fifo.sv =====
// Short queue of classified work between the front and the back.
// Uses isd_pkg for the entry type.
`default_nettype none

module isd_fifo
  import isd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire isd_op_t push_op,
  output logic         full,
  input  wire logic    pop,
  output isd_op_t      head,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  isd_op_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isd_back.sv =====
// Back of the deframer: splits queued work into result transfers through an
// output register. Uses isd_pkg and isd_if.
`default_nettype none

module isd_back
  import isd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire isd_op_t  head,
  input  wire logic     empty,
  output logic          pop,
  isd_result_if.source  result_ch
);

  logic               out_valid;
  logic               smp_done;
  logic               load;
  logic               take_smp;
  logic               r_kind;
  logic [3:0]         r_chan;
  logic signed [31:0] r_value;
  logic               r_send;
  logic               r_status;
  logic [15:0]        r_total;
  logic [31:0]        r_dtime;
  logic               r_last;

  // Load a new result when the output register is free or being taken
  always_comb begin
    load     = !empty && (!out_valid || result_ch.ready);
    take_smp = head.has_smp && !smp_done;
    pop      = load && !(take_smp && head.has_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      smp_done  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        smp_done  <= take_smp && head.has_sum;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_smp) begin
        r_kind   <= RK_SAMPLE;
        r_chan   <= head.chan;
        r_value  <= head.value;
        r_send   <= head.send;
        r_status <= FS_OK;
        r_total  <= '0;
        r_dtime  <= '0;
        r_last   <= !head.has_sum;
      end else begin
        r_kind   <= RK_SUMMARY;
        r_chan   <= '0;
        r_value  <= '0;
        r_send   <= 1'b0;
        r_status <= head.status;
        r_total  <= head.total;
        r_dtime  <= head.dtime;
        r_last   <= 1'b1;
      end
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.result_kind   = r_kind;
  assign result_ch.channel_index = r_chan;
  assign result_ch.sample_value  = r_value;
  assign result_ch.sample_end    = r_send;
  assign result_ch.frame_status  = r_status;
  assign result_ch.sample_total  = r_total;
  assign result_ch.device_time   = r_dtime;
  assign result_ch.last_result   = r_last;

endmodule

`default_nettype wire

// ===== rtl/interleaved_sample_deframer_unit.sv =====
// Top level of the interleaved sample deframer: front, queue and back.
// Uses isd_pkg, isd_if, isd_front, isd_fifo and isd_back.
//
//   channel     role    carries
//   byte_ch     sink    data_byte, frame_start, frame_length
//   result_ch   source  sample or end-of-frame summary fields, last_result
//   cfg_*       write   register index and data, no read-back
//
// A byte inside a frame is stepped as it is taken. A start byte that passes the
// quick length checks waits in FR_DIV for the 16-step bit-serial remainder unit
// that tests the data length against the stride; one that fails them goes straight
// to FR_FIN. Reset is synchronous and leaves no frame open. A stalled result side
// fills the queue before the byte side stops taking bytes.
`default_nettype none

module interleaved_sample_deframer_unit
  import isd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  isd_byte_if.sink        byte_ch,
  isd_result_if.source    result_ch
);

  logic    q_push;
  isd_op_t q_push_op;
  logic    q_full;
  logic    q_pop;
  isd_op_t q_head;
  logic    q_empty;

  isd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_ch   (byte_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_op   (q_push_op)
  );

  isd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  isd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/isd_checker.sv =====
// Port-level checks of the deframer and the bind that attaches them.
// Uses isd_pkg; binds to interleaved_sample_deframer_unit.
`default_nettype none

module isd_checker
  import isd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        byte_valid,
  input wire logic        byte_ready,
  input wire logic        frame_start,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic        result_kind,
  input wire logic [31:0] sample_value,
  input wire logic [15:0] sample_total,
  input wire logic        last_result
);

  logic sum_pending;

  // Track a sample transfer that announced a summary still to come
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_pending <= 1'b0;
    end else if (result_valid && result_ready) begin
      sum_pending <= (result_kind == RK_SAMPLE) && !last_result;
    end
  end

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_kind) && $stable(sample_value) &&
      $stable(sample_total) && $stable(last_result))
    else $error("stalled result changed or dropped");

  // A sample that is not last is followed by the summary of the same byte
  a_summary_follows: assert property (@(posedge clk) disable iff (rst)
    sum_pending && result_valid |-> result_kind == RK_SUMMARY)
    else $error("summary missing after sample marked not last");

  // The start byte stalls the byte side while its length is checked
  a_start_stall: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && frame_start |=> !byte_ready)
    else $error("byte accepted right after a start byte");

endmodule

bind interleaved_sample_deframer_unit isd_checker u_isd_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_ch.valid),
  .byte_ready   (byte_ch.ready),
  .frame_start  (byte_ch.frame_start),
  .result_valid (result_ch.valid),
  .result_ready (result_ch.ready),
  .result_kind  (result_ch.result_kind),
  .sample_value (result_ch.sample_value),
  .sample_total (result_ch.sample_total),
  .last_result  (result_ch.last_result)
);

`default_nettype wire

// ===== sim/interleaved_sample_deframer_unit_test.sv =====
// Self-checking testbench of interleaved_sample_deframer_unit: directed and random frames.
// Needs isd_pkg, isd_byte_if, isd_result_if and the block itself; a built-in
// deframer predictor checks every result transfer.
`default_nettype none

module interleaved_sample_deframer_unit_test;
  import isd_pkg::*;

  localparam int RANDOM_ITEMS  = 850;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LINES  = 200;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [15:0] length;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  chan;
    logic [31:0] value;
    logic        send_end;
    logic        status;
    logic [15:0] total;
    logic [31:0] dtime;
    logic        last;
  } deframe_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  isd_byte_if   byte_ch ();
  isd_result_if result_ch ();

  interleaved_sample_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  // Layout registers as the block holds them
  logic [6:0] cfg_channels;
  logic [2:0] cfg_sample_bytes;
  logic [7:0] cfg_header;
  logic [7:0] cfg_trailer;
  logic       cfg_lsb_first;

  // Deframer state mirror
  logic [15:0] frame_pos;
  logic [15:0] frame_left;
  logic        frame_open;
  logic [1:0]  sample_byte;
  logic [5:0]  chan_idx;
  logic [31:0] sample_acc;
  logic [15:0] full_samples;
  logic [31:0] stamp_acc;

  byte_item_t      pending_bytes[$];
  deframe_result_t expected_results[$];

  int items_queued   = 0;
  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int src_idle_pct   = 32;
  int snk_idle_pct   = 32;
  int hold_left      = 0;
  logic hold_arm;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sign-extend a gathered sample of nbytes bytes; four bytes stand as they are
  function automatic logic [31:0] extend_sample(input logic [31:0] v, input int unsigned nbytes);
    logic [31:0] mask;
    int unsigned bits;
    if (nbytes >= 4 || nbytes == 0) return v;
    bits = nbytes * 8;
    mask = (32'h1 << bits) - 32'h1;
    v = v & mask;
    if (v[bits-1]) v = v | ~mask;
    return v;
  endfunction

  // Advance the mirror by one accepted byte and queue the results it causes
  task automatic deframe_byte(input logic [7:0] b, input logic st, input logic [15:0] len);
    int unsigned stride, overhead, tidx, tbytes, bis, c, nch;
    bit bad;
    logic [31:0] wide;
    deframe_result_t res[2];
    int n;
    n = 0;
    wide = {24'd0, b};
    res[0] = '0;
    res[1] = '0;
    if (st) begin
      stride = cfg_channels * cfg_sample_bytes;
      overhead = cfg_header + cfg_trailer;
      bad = cfg_channels > MAX_CHANNELS || cfg_sample_bytes > MAX_SAMPLE_BYTES ||
            stride == 0 || len < overhead;
      if (!bad && ((len - overhead) % stride) != 0) bad = 1'b1;
      frame_open = 1'b0;
      frame_left = '0;
      frame_pos = '0;
      sample_byte = '0;
      chan_idx = '0;
      sample_acc = '0;
      full_samples = '0;
      stamp_acc = '0;
      if (bad || len == 0) begin
        res[0].kind = RK_SUMMARY;
        res[0].status = bad ? FS_MALFORMED : FS_OK;
        res[0].last = 1'b1;
        expected_results.push_back(res[0]);
        return;
      end
      frame_open = 1'b1;
      frame_left = len;
    end

    // Drop bytes outside an open frame
    if (!frame_open || frame_left == 0) return;

    if (frame_left <= cfg_trailer) begin
      // Trailer: the first few bytes build the device timestamp
      tidx = cfg_trailer - frame_left;
      tbytes = cfg_trailer < MAX_TIME_BYTES ? cfg_trailer : MAX_TIME_BYTES;
      if (tidx < tbytes) begin
        if (cfg_lsb_first) stamp_acc = stamp_acc | (wide << (8 * tidx));
        else stamp_acc = {stamp_acc[23:0], b};
      end
    end else if (frame_pos >= cfg_header) begin
      // Sample data: gather bytes, emit on the last byte of a channel sample
      bis = sample_byte;
      if (cfg_lsb_first) sample_acc = sample_acc | (wide << (8 * bis));
      else sample_acc = {sample_acc[23:0], b};
      if (bis + 1 >= cfg_sample_bytes || bis == 3) begin
        c = chan_idx;
        nch = cfg_channels < MAX_EMIT_CHANNELS ? cfg_channels : MAX_EMIT_CHANNELS;
        if (c < MAX_EMIT_CHANNELS) begin
          res[n].kind = RK_SAMPLE;
          res[n].chan = c[3:0];
          res[n].value = extend_sample(sample_acc, bis + 1);
          res[n].send_end = (c + 1 >= nch);
          n++;
        end
        sample_acc = '0;
        sample_byte = '0;
        if (c + 1 >= cfg_channels) begin
          chan_idx = '0;
          full_samples = full_samples + 16'd1;
        end else begin
          chan_idx = 6'(c + 1);
        end
      end else begin
        sample_byte = 2'(bis + 1);
      end
    end

    frame_pos = frame_pos + 16'd1;
    frame_left = frame_left - 16'd1;

    // Close the frame with a summary on its last byte
    if (frame_left == 0) begin
      res[n].kind = RK_SUMMARY;
      res[n].status = FS_OK;
      res[n].total = full_samples;
      res[n].dtime = stamp_acc;
      n++;
      frame_open = 1'b0;
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LINES) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result();
    deframe_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", result_ch.result_kind));
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", result_ch.result_kind, want.kind);
      check_field("channel_index", result_ch.channel_index, want.chan);
      check_field("sample_value", result_ch.sample_value, want.value);
      check_field("sample_end", result_ch.sample_end, want.send_end);
      check_field("frame_status", result_ch.frame_status, want.status);
      check_field("sample_total", result_ch.sample_total, want.total);
      check_field("device_time", result_ch.device_time, want.dtime);
      check_field("last_result", result_ch.last_result, want.last);
    end
    results_seen++;
  endtask

  // Byte driver: predict on each transfer, then offer the next pending byte or idle
  always @(posedge clk) begin : drive_bytes
    byte_item_t item;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready)
        deframe_byte(byte_ch.data_byte, byte_ch.frame_start, byte_ch.frame_length);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          item = pending_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= item.data;
          byte_ch.frame_start <= item.start;
          byte_ch.frame_length <= item.length;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer, stall at random or during a hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_result();
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Receiver hold-off counter
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_arm) hold_left <= HOLD_CYCLES;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic st, input logic [15:0] len);
    byte_item_t item;
    item.data = b;
    item.start = st;
    item.length = len;
    pending_bytes.push_back(item);
    items_queued++;
  endtask

  // Queue a well-formed frame of nsamp full samples; keep > 0 cuts it short
  task automatic queue_frame(input int nsamp, input int keep);
    int unsigned len;
    int count;
    len = cfg_header + cfg_trailer + nsamp * cfg_channels * cfg_sample_bytes;
    count = (len == 0) ? 1 : int'(len);
    if (keep > 0 && keep < count) count = keep;
    queue_byte(rand_byte(), 1'b1, len[15:0]);
    for (int i = 1; i < count; i++) queue_byte(rand_byte(), 1'b0, 16'($urandom));
  endtask

  // Stray bytes, random-length starts and cut-off frames
  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, 3)) queue_byte(rand_byte(), 1'b0, 16'($urandom));
      1: begin
        queue_byte(rand_byte(), 1'b1, 16'($urandom));
        repeat ($urandom_range(0, 3)) queue_byte(rand_byte(), 1'b0, 16'($urandom));
      end
      default: queue_frame($urandom_range(1, 2), $urandom_range(1, 3));
    endcase
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_CHANNEL_COUNT:    cfg_channels = data[6:0];
      CFG_BYTES_PER_SAMPLE: cfg_sample_bytes = data[2:0];
      CFG_HEADER_LENGTH:    cfg_header = data;
      CFG_TRAILER_LENGTH:   cfg_trailer = data;
      CFG_LSB_FIRST:        cfg_lsb_first = data[0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_layout(input logic [7:0] chans, input logic [7:0] nbytes,
                              input logic [7:0] hdr, input logic [7:0] trl, input logic lsb);
    write_reg(CFG_CHANNEL_COUNT, chans);
    write_reg(CFG_BYTES_PER_SAMPLE, nbytes);
    write_reg(CFG_HEADER_LENGTH, hdr);
    write_reg(CFG_TRAILER_LENGTH, trl);
    write_reg(CFG_LSB_FIRST, {7'd0, lsb});
    finish_writes();
    @(negedge clk);
  endtask

  // Wait until the block has drained, then let it finish any start-byte check
  task automatic settle();
    while (pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pick a random layout, mostly small and well-formed
  task automatic random_layout();
    logic [7:0] chans, nbytes;
    case ($urandom_range(0, 19))
      0: chans = 8'd0;
      1: chans = 8'($urandom_range(65, 127));
      2: chans = 8'($urandom_range(7, 20));
      default: chans = 8'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 14))
      0: nbytes = 8'd0;
      1: nbytes = 8'($urandom_range(5, 7));
      default: nbytes = 8'($urandom_range(1, 4));
    endcase
    write_layout(chans, nbytes, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 6)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(input int phase_items);
    int first, max_samples;
    first = items_queued;
    max_samples = (cfg_channels * cfg_sample_bytes > 32) ? 1 : 3;
    while (items_queued - first < phase_items) begin
      if ($urandom_range(0, 3) != 0) queue_frame($urandom_range(0, max_samples), 0);
      else queue_noise();
    end
  endtask

  initial begin
    int directed_items, phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_arm = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.frame_start = 1'b0;
    byte_ch.frame_length = '0;
    result_ch.ready = 1'b0;

    // Reset layout
    cfg_channels = 7'd1;
    cfg_sample_bytes = 3'd2;
    cfg_header = 8'd0;
    cfg_trailer = 8'd0;
    cfg_lsb_first = 1'b1;
    frame_pos = '0;
    frame_left = '0;
    frame_open = 1'b0;
    sample_byte = '0;
    chan_idx = '0;
    sample_acc = '0;
    full_samples = '0;
    stamp_acc = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: stray byte, sample with summary on one byte, zero length,
    // bad length, restart, largest length
    queue_byte(8'h5A, 1'b0, 16'hFFFF);
    queue_byte(8'h00, 1'b1, 16'd2);
    queue_byte(8'h80, 1'b0, 16'h0000);
    queue_byte(8'hFF, 1'b1, 16'd0);
    queue_byte(8'h11, 1'b1, 16'd3);
    queue_byte(8'h22, 1'b0, 16'h0000);
    queue_byte(8'hFF, 1'b1, 16'd6);
    queue_byte(8'h7F, 1'b0, 16'h0000);
    queue_byte(8'hFF, 1'b1, 16'd2);
    queue_byte(8'h7F, 1'b0, 16'h0000);
    queue_byte(8'h01, 1'b1, 16'hFFFF);

    // Change the sample size in the middle of a channel sample
    queue_byte(8'h34, 1'b1, 16'd4);
    settle();
    write_reg(CFG_BYTES_PER_SAMPLE, 8'd1);
    finish_writes();
    @(negedge clk);
    queue_byte(8'h92, 1'b0, 16'h0000);
    queue_byte(8'h80, 1'b0, 16'h0000);
    queue_byte(8'h01, 1'b0, 16'h0000);
    settle();

    // Layouts that reject every frame
    write_reg(CFG_CHANNEL_COUNT, 8'd0);
    finish_writes();
    @(negedge clk);
    queue_byte(8'hAA, 1'b1, 16'd0);
    settle();
    write_reg(CFG_CHANNEL_COUNT, 8'd127);
    finish_writes();
    @(negedge clk);
    queue_byte(8'h55, 1'b1, 16'd127);
    settle();
    write_layout(8'd1, 8'd7, 8'd0, 8'd0, 1'b1);
    queue_byte(8'h0F, 1'b1, 16'd7);
    settle();
    directed_items = items_queued;

    // Random phases; the first few carry the extreme layouts and the pressure tests
    phase = 0;
    while (items_queued - directed_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          // Widest layout: channels past the emitted ones are skipped
          write_layout(8'd64, 8'd1, 8'd1, 8'd4, 1'b0);
          queue_frame(1, 0);
        end
        1: begin
          // Every byte is a sample: hold the receiver off until the input stalls
          write_layout(8'd2, 8'd1, 8'd0, 8'd0, 1'b1);
          random_phase(60);
          @(posedge clk);
          hold_arm <= 1'b1;
          @(posedge clk);
          hold_arm <= 1'b0;
        end
        2: begin
          // Longest header and trailer
          write_layout(8'd1, 8'd1, 8'd255, 8'd255, 1'($urandom_range(0, 1)));
          queue_byte(8'h3C, 1'b1, 16'd100);
          queue_frame(1, 0);
        end
        3: begin
          // Full-rate stretch on both sides
          src_idle_pct = 0;
          snk_idle_pct = 0;
          write_layout(8'd3, 8'd4, 8'd2, 8'd4, 1'b1);
          random_phase(100);
        end
        4: begin
          write_layout(8'd17, 8'd3, 8'd0, 8'd3, 1'b0);
          queue_frame(1, 0);
          queue_frame(0, 0);
        end
        default: begin
          random_layout();
          random_phase($urandom_range(40, 90));
        end
      endcase
      settle();
      src_idle_pct = 32;
      snk_idle_pct = 32;
      phase++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/isd_pkg.sv
rtl/isd_if.sv
rtl/isd_mod.sv
rtl/isd_front.sv
rtl/isd_fifo.sv
rtl/isd_back.sv
rtl/interleaved_sample_deframer_unit.sv
rtl/isd_checker.sv
sim/interleaved_sample_deframer_unit_test.sv
